/* rtl/lpi_pkg.sv */
// Shared types, constants and fixed-point helpers for the Lorenz particle integrator.
package lpi_pkg;

   // Store size and fixed-point format
   localparam int MAX_PARTICLES = 64;
   localparam int FRAC_BITS     = 16;
   localparam int IDX_W         = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

   // Field widths
   localparam int POS_W     = 32;
   localparam int COEF_W    = 24;
   localparam int DT_W      = 16;
   localparam int SLOT_W    = 6;
   localparam int INDEX_W   = 6;
   localparam int CNT_REG_W = 7;
   localparam int CSR_IDX_W = 3;
   localparam int ENTRY_W   = 3 * POS_W;

   // Internal arithmetic widths
   localparam int TERM_W = 47;
   localparam int WIDE_W = 72;
   localparam int MH_W   = TERM_W - FRAC_BITS + DT_W + 1;
   localparam int ML_W   = FRAC_BITS + DT_W;

   // Request actions
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RHO    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT  = 3'd4;

   // Register reset values: sigma 10.0, rho 52.5, beta 2.66 rounded
   localparam logic [COEF_W-1:0] SIGMA_RST = COEF_W'(64'd10 << FRAC_BITS);
   localparam logic [COEF_W-1:0] RHO_RST   = COEF_W'((64'd105 << FRAC_BITS) / 64'd2);
   localparam logic [COEF_W-1:0] BETA_RST  =
      COEF_W'(((64'd266 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [CNT_REG_W-1:0] COUNT_RST = CNT_REG_W'(64);

   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   // Coefficients and time step seen by the step pipeline
   typedef struct packed {
      logic [COEF_W-1:0] sigma;
      logic [COEF_W-1:0] rho;
      logic [COEF_W-1:0] beta;
      logic [DT_W-1:0]   dt;
   } coef_type;

   // Per-word tag that rides along the pipeline
   typedef struct packed {
      logic [IDX_W-1:0] slot;
      logic             last;
   } tag_type;

   // Partial products of term*dt: high part times dt, low fraction times dt
   typedef struct packed {
      logic signed [MH_W-1:0] mh;
      logic [ML_W-1:0]        ml;
   } scale_type;

   // Clamp to signed TERM_W bits
   function automatic term_type sat_term(input wide_type v);
      logic [WIDE_W-TERM_W:0] hi;
      term_type r;
      hi = v[WIDE_W-1:TERM_W-1];
      priority if (&hi || ~|hi) r = v[TERM_W-1:0];
      else if (v[WIDE_W-1])     r = {1'b1, {(TERM_W-1){1'b0}}};
      else                      r = {1'b0, {(TERM_W-1){1'b1}}};
      return r;
   endfunction

   // Clamp to signed POS_W bits
   function automatic pos_type sat_pos(input wide_type v);
      logic [WIDE_W-POS_W:0] hi;
      pos_type r;
      hi = v[WIDE_W-1:POS_W-1];
      priority if (&hi || ~|hi) r = v[POS_W-1:0];
      else if (v[WIDE_W-1])     r = {1'b1, {(POS_W-1){1'b0}}};
      else                      r = {1'b0, {(POS_W-1){1'b1}}};
      return r;
   endfunction

   // t*dt split as (t>>F)*dt*2^F + frac(t)*dt, so the floor shift stays exact
   function automatic scale_type dt_scale(input term_type t, input logic [DT_W-1:0] dt);
      logic signed [TERM_W-FRAC_BITS-1:0] th;
      logic [FRAC_BITS-1:0] tl;
      scale_type s;
      th   = t[TERM_W-1:FRAC_BITS];
      tl   = t[FRAC_BITS-1:0];
      s.mh = th * $signed({1'b0, dt});
      s.ml = tl * dt;
      return s;
   endfunction

   // floor(t*dt / 2^F) from the two partial products
   function automatic wide_type dt_combine(input scale_type s);
      wide_type a;
      wide_type b;
      a = wide_type'(s.mh);
      b = wide_type'(s.ml >> FRAC_BITS);
      return a + b;
   endfunction

endpackage

/* rtl/lpi_if.sv */
// Request and response channel interfaces of the Lorenz particle integrator.
interface lpi_req_if;
   import lpi_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    action;
   logic [INDEX_W-1:0]      index;
   logic signed [POS_W-1:0] load_x;
   logic signed [POS_W-1:0] load_y;
   logic signed [POS_W-1:0] load_z;
   logic [DT_W-1:0]         step_size;

   modport source (output valid, action, index, load_x, load_y, load_z, step_size,
                   input ready);
   modport sink   (input valid, action, index, load_x, load_y, load_z, step_size,
                   output ready);
endinterface

interface lpi_rsp_if;
   import lpi_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [SLOT_W-1:0]       slot;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic                    last;

   modport source (output valid, slot, pos_x, pos_y, pos_z, last, input ready);
   modport sink   (input valid, slot, pos_x, pos_y, pos_z, last, output ready);
endinterface

/* rtl/lpi_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
module lpi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/lpi_step_pipe.sv */
// Twelve-stage Euler step pipeline: x, then y with new x, then z with new x and y.
module lpi_step_pipe (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  lpi_pkg::tag_type  in_tag,
   input  lpi_pkg::pos_type  in_x,
   input  lpi_pkg::pos_type  in_y,
   input  lpi_pkg::pos_type  in_z,
   input  lpi_pkg::coef_type coef,
   output logic              out_vld,
   output lpi_pkg::tag_type  out_tag,
   output lpi_pkg::pos_type  out_x,
   output lpi_pkg::pos_type  out_y,
   output lpi_pkg::pos_type  out_z,
   output logic              busy
);
   import lpi_pkg::*;

   localparam int NS    = 12;
   localparam int D_W   = POS_W + 1;
   localparam int RZ_W  = POS_W + 2;
   localparam int P_W   = COEF_W + 1 + D_W;
   localparam int Q_W   = POS_W + RZ_W;
   localparam int XY_W  = 2 * POS_W;
   localparam int BZ_W  = COEF_W + 1 + POS_W;

   logic [NS-1:0] vld_ff, vld_in;
   tag_type tag_ff [NS];
   tag_type tag_in [NS];
   pos_type x_ff [NS];
   pos_type x_in [NS];
   pos_type y_ff [NS];
   pos_type y_in [NS];
   pos_type z_ff [NS];
   pos_type z_in [NS];

   logic signed [D_W-1:0]  d_ff, d_in;
   logic signed [P_W-1:0]  p_ff, p_in;
   scale_type              sca_ff, sca_in;
   logic signed [RZ_W-1:0] rz_ff, rz_in;
   logic signed [Q_W-1:0]  q_ff, q_in;
   term_type               tb_ff, tb_in;
   scale_type              scb_ff, scb_in;
   logic signed [XY_W-1:0] xy_ff, xy_in;
   logic signed [BZ_W-1:0] bz_ff, bz_in;
   term_type               tc_ff, tc_in;
   scale_type              scc_ff, scc_in;

   always_comb begin
      // default: every word moves one stage on
      vld_in    = {vld_ff[NS-2:0], in_vld};
      tag_in[0] = in_tag;
      x_in[0]   = in_x;
      y_in[0]   = in_y;
      z_in[0]   = in_z;
      for (int i = 1; i < NS; i++) begin
         tag_in[i] = tag_ff[i-1];
         x_in[i]   = x_ff[i-1];
         y_in[i]   = y_ff[i-1];
         z_in[i]   = z_ff[i-1];
      end

      // x: sigma*(y-x), scaled by dt
      d_in    = D_W'(in_y) - D_W'(in_x);
      p_in    = $signed({1'b0, coef.sigma}) * d_ff;
      sca_in  = dt_scale(sat_term(wide_type'(p_ff >>> FRAC_BITS)), coef.dt);
      x_in[3] = sat_pos(wide_type'(x_ff[2]) + dt_combine(sca_ff));
      rz_in   = RZ_W'($signed({1'b0, coef.rho})) + RZ_W'(z_ff[2]);

      // y: x*(rho+z) - y with the new x
      q_in    = x_ff[3] * rz_ff;
      tb_in   = sat_term(wide_type'(sat_term(wide_type'(q_ff >>> FRAC_BITS)))
                         - wide_type'(y_ff[4]));
      scb_in  = dt_scale(tb_ff, coef.dt);
      y_in[7] = sat_pos(wide_type'(y_ff[6]) + dt_combine(scb_ff));

      // z: x*y + beta*z with the new x and y, subtracted
      xy_in    = x_ff[7] * y_ff[7];
      bz_in    = $signed({1'b0, coef.beta}) * z_ff[7];
      tc_in    = sat_term(wide_type'(xy_ff >>> FRAC_BITS) + wide_type'(bz_ff >>> FRAC_BITS));
      scc_in   = dt_scale(tc_ff, coef.dt);
      z_in[11] = sat_pos(wide_type'(z_ff[10]) - dt_combine(scc_ff));
   end

   // Whole pipeline holds while the output word waits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         tag_ff <= tag_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         d_ff   <= d_in;
         p_ff   <= p_in;
         sca_ff <= sca_in;
         rz_ff  <= rz_in;
         q_ff   <= q_in;
         tb_ff  <= tb_in;
         scb_ff <= scb_in;
         xy_ff  <= xy_in;
         bz_ff  <= bz_in;
         tc_ff  <= tc_in;
         scc_ff <= scc_in;
      end
   end

   assign out_vld = vld_ff[NS-1];
   assign out_tag = tag_ff[NS-1];
   assign out_x   = x_ff[NS-1];
   assign out_y   = y_ff[NS-1];
   assign out_z   = z_ff[NS-1];
   assign busy    = |vld_ff;
endmodule

/* rtl/lorenz_particle_integrator.sv */
// Top level: register file, tick sequencer, position RAM and step pipeline.
//
// Usage
//   req_ch carries one word per request. action LOAD writes load_x/y/z into
//   slot index (indexes at or above the store size are dropped). action TICK
//   advances particles 0 .. count-1 by one Euler step of step_size (no change
//   while paused) and returns one rsp_ch word per particle in slot order, with
//   last set on the final one. count is particle_count clamped to the store size;
//   zero returns nothing.
// Timing
//   A tick streams one particle per cycle, while rsp_ch does not stall, from
//   the position RAM through a 12-stage step pipeline and writes each result
//   back as it is delivered. The tick holds the request channel until the RAM
//   walk is done and the pipeline has drained. req_ch.ready is high only
//   between requests.
// Reset and stalls
//   Reset clears all positions (per-slot valid bits, unwritten slots read as zero)
//   and loads the register defaults. A stall on rsp_ch freezes the RAM read and the
//   whole pipeline; nothing is lost or repeated. Registers on the csr port must be
//   written only while no request is in flight; the block does not enforce this.
module lorenz_particle_integrator (
   input  logic                             clock,
   input  logic                             reset,
   lpi_req_if.sink                          req_ch,
   lpi_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [lpi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lpi_pkg::COEF_W-1:0]       csr_wdata
);
   import lpi_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_type;

   state_type state_ff, state_in;
   logic [COEF_W-1:0]        sigma_ff, rho_ff, beta_ff;
   logic                     paused_ff;
   logic [CNT_REG_W-1:0]     count_ff;
   logic [CNT_W-1:0]         cnt_ff, cnt_in, ptr_ff, ptr_in, cnt_sat;
   logic [DT_W-1:0]          dt_ff, dt_in;
   logic [MAX_PARTICLES-1:0] ent_vld_ff, ent_vld_in;
   logic                     rd_vld_ff, rd_vld_in, rd_hit_ff, rd_hit_in;
   tag_type                  rd_tag_ff, rd_tag_in;

   logic             adv, pipe_busy, req_fire, rsp_fire, load_we, wb_we, ram_we;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data, rd_masked;
   pos_type          out_x, out_y, out_z;
   logic             out_vld;
   tag_type          out_tag;
   coef_type         coef;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff  <= SIGMA_RST;
         rho_ff    <= RHO_RST;
         beta_ff   <= BETA_RST;
         paused_ff <= 1'b0;
         count_ff  <= COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SIGMA:  sigma_ff  <= csr_wdata;
            CSR_RHO:    rho_ff    <= csr_wdata;
            CSR_BETA:   beta_ff   <= csr_wdata;
            CSR_PAUSED: paused_ff <= csr_wdata[0];
            CSR_COUNT:  count_ff  <= csr_wdata[CNT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshakes and RAM write port (loads while idle, write-back on delivery)
   assign adv       = !out_vld || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign rsp_fire  = out_vld && rsp_ch.ready;
   assign load_we   = req_fire && (req_ch.action == ACT_LOAD)
                      && (32'(req_ch.index) < 32'(MAX_PARTICLES));
   assign wb_we     = rsp_fire;
   assign ram_we    = load_we || wb_we;
   assign wr_addr   = load_we ? IDX_W'(req_ch.index) : out_tag.slot;
   assign wr_data   = load_we ? {req_ch.load_x, req_ch.load_y, req_ch.load_z}
                              : {out_x, out_y, out_z};
   assign rd_addr   = ptr_ff[IDX_W-1:0];
   assign cnt_sat   = (32'(count_ff) > 32'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES)
                                                           : CNT_W'(count_ff);

   // Tick sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ptr_in     = ptr_ff;
      dt_in      = dt_ff;
      rd_vld_in  = rd_vld_ff;
      rd_hit_in  = rd_hit_ff;
      rd_tag_in  = rd_tag_ff;
      ent_vld_in = ent_vld_ff;
      if (ram_we) begin
         ent_vld_in[wr_addr] = 1'b1;
      end
      if (adv) begin
         rd_vld_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.action == ACT_TICK)) begin
               cnt_in = cnt_sat;
               ptr_in = '0;
               dt_in  = paused_ff ? '0 : req_ch.step_size;
               if (cnt_sat != '0) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (adv) begin
               rd_vld_in      = 1'b1;
               rd_hit_in      = ent_vld_ff[rd_addr];
               rd_tag_in.slot = rd_addr;
               rd_tag_in.last = (ptr_ff == CNT_W'(cnt_ff - CNT_W'(1)));
               ptr_in         = CNT_W'(ptr_ff + CNT_W'(1));
               if (rd_tag_in.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         ent_vld_ff <= '0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         ent_vld_ff <= ent_vld_in;
      end
      cnt_ff    <= cnt_in;
      ptr_ff    <= ptr_in;
      dt_ff     <= dt_in;
      rd_hit_ff <= rd_hit_in;
      rd_tag_ff <= rd_tag_in;
   end

   // Position store
   lpi_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PARTICLES)
   ) u_pos_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (adv),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   // Slots never written since reset read as zero
   assign rd_masked = rd_hit_ff ? rd_data : '0;

   assign coef.sigma = sigma_ff;
   assign coef.rho   = rho_ff;
   assign coef.beta  = beta_ff;
   assign coef.dt    = dt_ff;

   lpi_step_pipe u_step_pipe (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (rd_vld_ff),
      .in_tag  (rd_tag_ff),
      .in_x    (rd_masked[3*POS_W-1:2*POS_W]),
      .in_y    (rd_masked[2*POS_W-1:POS_W]),
      .in_z    (rd_masked[POS_W-1:0]),
      .coef    (coef),
      .out_vld (out_vld),
      .out_tag (out_tag),
      .out_x   (out_x),
      .out_y   (out_y),
      .out_z   (out_z),
      .busy    (pipe_busy)
   );

   // Response word
   assign rsp_ch.valid = out_vld;
   assign rsp_ch.slot  = SLOT_W'(out_tag.slot);
   assign rsp_ch.pos_x = out_x;
   assign rsp_ch.pos_y = out_y;
   assign rsp_ch.pos_z = out_z;
   assign rsp_ch.last  = out_tag.last;

   // Requests are taken only with the pipeline empty
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> (!pipe_busy && !rd_vld_ff))
      else $error("request taken with a tick in flight");

   // The walk never reads past the clamped count
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (ptr_ff < cnt_ff))
      else $error("read pointer beyond particle count");

   // Load and write-back never share the write port
   a_wr_port: assert property (@(posedge clock) disable iff (reset)
      !(load_we && wb_we))
      else $error("load collides with write-back");

   // The last read is only issued once, and leaves the sequencer draining
   a_last_drain: assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff && rd_tag_ff.last) |-> (state_ff == ST_DRAIN))
      else $error("last read issued outside drain");

   // After the last word goes out, nothing is left in the pipeline
   a_last_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && out_tag.last) |=> (!pipe_busy && (state_ff != ST_RUN)))
      else $error("words left behind the last one");
endmodule

/* tb/sv/tb_lorenz_particle_integrator.sv */
// Self-checking testbench for the Lorenz particle integrator: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_lorenz_particle_integrator;
   import lpi_pkg::*;

   // Row kinds of the stimulus plan
   typedef enum logic [1:0] {ROW_LOAD, ROW_TICK, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [INDEX_W-1:0]   idx;
      pos_type              x;
      pos_type              y;
      pos_type              z;
      logic [DT_W-1:0]      dt;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [COEF_W-1:0]    reg_val;
      bit                   known;     // expected position typed in the row
      pos_type              ex;
      pos_type              ey;
      pos_type              ez;
   } plan_row_type;

   // One expected position word
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      pos_type           x;
      pos_type           y;
      pos_type           z;
      logic              last;
   } pos_word_type;

   localparam longint TERM_MAX     = (longint'(1) <<< (TERM_W - 1)) - 1;
   localparam longint TERM_MIN     = -TERM_MAX - 1;
   localparam longint POS_MAX      = (longint'(1) <<< (POS_W - 1)) - 1;
   localparam longint POS_MIN      = -POS_MAX - 1;
   localparam int     SETTLE_CYCLES = 30;
   localparam int     SEG_ITEMS     = 46;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COEF_W-1:0]    csr_wdata;

   lpi_req_if req_ch ();
   lpi_rsp_if rsp_ch ();

   lorenz_particle_integrator uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the block: position store and registers
   pos_type              mem_x [MAX_PARTICLES];
   pos_type              mem_y [MAX_PARTICLES];
   pos_type              mem_z [MAX_PARTICLES];
   logic [COEF_W-1:0]    sigma_r;
   logic [COEF_W-1:0]    rho_r;
   logic [COEF_W-1:0]    beta_r;
   logic                 paused_r;
   logic [CNT_REG_W-1:0] count_r;

   pos_word_type pending_words[$];
   plan_row_type plan[$];

   int gap_pct;
   int stall_pct;
   int n_bad;
   int n_loads;
   int n_ticks;
   int n_words;
   int n_regs;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic flag_error(input string msg);
      n_bad++;
      $display("ERROR @%0t: %s", $time, msg);
   endtask

   function automatic longint floor_frac(input longint v);
      return v >>> FRAC_BITS;
   endfunction

   function automatic longint clamp_term(input longint v);
      if (v > TERM_MAX) return TERM_MAX;
      if (v < TERM_MIN) return TERM_MIN;
      return v;
   endfunction

   function automatic longint clamp_pos(input longint v);
      if (v > POS_MAX) return POS_MAX;
      if (v < POS_MIN) return POS_MIN;
      return v;
   endfunction

   function automatic int active_slots();
      int c;
      c = int'(count_r);
      return (c > MAX_PARTICLES) ? MAX_PARTICLES : c;
   endfunction

   // One forward-Euler Lorenz step of slot n, z mirrored
   function automatic void advance_particle(input int n, input logic [DT_W-1:0] step);
      longint px, py, pz, t, d, s, r, b;
      px = mem_x[n];
      py = mem_y[n];
      pz = mem_z[n];
      d  = step;
      s  = sigma_r;
      r  = rho_r;
      b  = beta_r;
      t  = clamp_term(floor_frac(s * (py - px)));
      px = clamp_pos(px + floor_frac(t * d));
      t  = clamp_term(floor_frac(px * (r + pz)));
      t  = clamp_term(t - py);
      py = clamp_pos(py + floor_frac(t * d));
      t  = clamp_term(floor_frac(px * py) + floor_frac(b * pz));
      pz = clamp_pos(pz - floor_frac(t * d));
      mem_x[n] = pos_type'(px);
      mem_y[n] = pos_type'(py);
      mem_z[n] = pos_type'(pz);
   endfunction

   // Row with the ignored request fields (index, positions, step) randomized
   function automatic plan_row_type blank_row(input row_kind_type kind);
      plan_row_type r;
      r.kind    = kind;
      r.idx     = INDEX_W'($urandom);
      r.x       = pos_type'($urandom);
      r.y       = pos_type'($urandom);
      r.z       = pos_type'($urandom);
      r.dt      = DT_W'($urandom);
      r.reg_idx = CSR_SIGMA;
      r.reg_val = '0;
      r.known   = 1'b0;
      r.ex      = '0;
      r.ey      = '0;
      r.ez      = '0;
      return r;
   endfunction

   function automatic void add_load(input int idx, input pos_type x, input pos_type y,
                                    input pos_type z);
      plan_row_type r;
      r = blank_row(ROW_LOAD);
      r.idx = INDEX_W'(idx);
      r.x   = x;
      r.y   = y;
      r.z   = z;
      plan.push_back(r);
   endfunction

   function automatic void add_tick(input logic [DT_W-1:0] dt, input bit known,
                                    input pos_type ex, input pos_type ey, input pos_type ez);
      plan_row_type r;
      r = blank_row(ROW_TICK);
      r.dt    = dt;
      r.known = known;
      r.ex    = ex;
      r.ey    = ey;
      r.ez    = ez;
      plan.push_back(r);
   endfunction

   function automatic void add_reg(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [COEF_W-1:0] val);
      plan_row_type r;
      r = blank_row(ROW_REG);
      r.reg_idx = idx;
      r.reg_val = val;
      plan.push_back(r);
   endfunction

   // Directed table
   function automatic void build_plan();
      // Reset state is the origin, a fixed point even at the largest step
      add_tick(16'hFFFF, 1'b1, '0, '0, '0);
      // Paused single particle at the field extremes comes back untouched
      add_reg(CSR_COUNT, 24'd1);
      add_reg(CSR_PAUSED, 24'd1);
      add_load(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      add_tick(16'hFFFF, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      add_reg(CSR_PAUSED, 24'd0);
      // Zero step leaves positions alone
      add_tick(16'h0000, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      add_tick(16'hFFFF, 1'b0, '0, '0, '0);
      // Three particles: opposite extremes and a normal orbit point
      add_reg(CSR_COUNT, 24'd3);
      add_load(1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      add_load(2, 32'sh000A_0000, 32'sh000C_0000, 32'sh001E_0000);
      add_tick(16'h0148, 1'b0, '0, '0, '0);
      add_tick(16'hFFFF, 1'b0, '0, '0, '0);
      // Writes to unmapped registers change nothing
      for (int i = int'(CSR_COUNT) + 1; i < 2 ** CSR_IDX_W; i++)
         add_reg(CSR_IDX_W'(i), 24'hFF_FFFF);
      add_tick(16'h0100, 1'b0, '0, '0, '0);
      // Coefficient extremes
      add_reg(CSR_SIGMA, 24'd0);
      add_reg(CSR_RHO, 24'hFF_FFFF);
      add_reg(CSR_BETA, 24'hFF_FFFF);
      add_load(0, 32'sh0001_0000, 32'shFFFF_0000, 32'sh0002_0000);
      add_tick(16'h8000, 1'b0, '0, '0, '0);
      add_reg(CSR_SIGMA, 24'hFF_FFFF);
      add_reg(CSR_RHO, 24'd0);
      add_reg(CSR_BETA, 24'd0);
      add_tick(16'hFFFF, 1'b0, '0, '0, '0);
      // Count zero emits nothing; count above the store walks the whole store
      add_reg(CSR_COUNT, 24'd0);
      add_tick(16'h0400, 1'b0, '0, '0, '0);
      add_load(5, 32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0000_0000);
      add_reg(CSR_COUNT, 24'd127);
      add_tick(16'h00A0, 1'b0, '0, '0, '0);
      // Back to defaults
      add_reg(CSR_COUNT, 24'(COUNT_RST));
      add_reg(CSR_SIGMA, SIGMA_RST);
      add_reg(CSR_RHO, RHO_RST);
      add_reg(CSR_BETA, BETA_RST);
      add_tick(16'h0080, 1'b0, '0, '0, '0);
   endfunction

   // Register write once the block has gone quiet
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      req_ch.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      n_regs++;
      unique case (idx)
         CSR_SIGMA:  sigma_r  = val;
         CSR_RHO:    rho_r    = val;
         CSR_BETA:   beta_r   = val;
         CSR_PAUSED: paused_r = val[0];
         CSR_COUNT:  count_r  = val[CNT_REG_W-1:0];
         default: ;
      endcase
   endtask

   // Drive one request word, then predict what it causes
   task automatic send_item(input plan_row_type r);
      pos_word_type w;
      int           cnt;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= (r.kind == ROW_TICK) ? ACT_TICK : ACT_LOAD;
      req_ch.index     <= r.idx;
      req_ch.load_x    <= r.x;
      req_ch.load_y    <= r.y;
      req_ch.load_z    <= r.z;
      req_ch.step_size <= r.dt;
      do @(posedge clock); while (req_ch.ready !== 1'b1);

      if (r.kind == ROW_LOAD) begin
         mem_x[r.idx] = r.x;
         mem_y[r.idx] = r.y;
         mem_z[r.idx] = r.z;
         n_loads++;
      end else begin
         n_ticks++;
         cnt = active_slots();
         if (!paused_r) for (int n = 0; n < cnt; n++) advance_particle(n, r.dt);
         for (int k = 0; k < cnt; k++) begin
            w.slot = SLOT_W'(k);
            w.x    = r.known ? r.ex : mem_x[k];
            w.y    = r.known ? r.ey : mem_y[k];
            w.z    = r.known ? r.ez : mem_z[k];
            w.last = (k == cnt - 1);
            pending_words.push_back(w);
         end
      end
   endtask

   task automatic run_row(input plan_row_type r);
      if (r.kind == ROW_REG) write_reg(r.reg_idx, r.reg_val);
      else send_item(r);
   endtask

   // Mostly orbit-sized coordinates, some full range, some extremes
   function automatic pos_type random_coord();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return pos_type'(int'($urandom_range(0, 32'h50_0000)) - 32'sh28_0000);
      if (pick < 85) return pos_type'($urandom);
      case ($urandom_range(0, 3))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return 32'sh0000_0000;
         default: return 32'shFFFF_FFFF;
      endcase
   endfunction

   function automatic plan_row_type random_row();
      plan_row_type r;
      int           pick;
      int           lim;
      r = blank_row(ROW_LOAD);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r.kind = ROW_TICK;
         pick = $urandom_range(0, 99);
         if (pick < 75)      r.dt = DT_W'($urandom_range(0, 16'h0400));
         else if (pick < 90) r.dt = DT_W'($urandom);
         else if (pick < 95) r.dt = '0;
         else                r.dt = 16'hFFFF;
      end else begin
         // loads aimed mostly at the slots a tick will walk
         lim = active_slots();
         if (lim > 0 && $urandom_range(0, 99) < 80)
            r.idx = INDEX_W'($urandom_range(0, lim - 1));
         r.x = random_coord();
         r.y = random_coord();
         r.z = random_coord();
      end
      return r;
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef(input logic [COEF_W-1:0] dflt);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return dflt;
      if (pick < 80) return COEF_W'($urandom_range(0, 40 << FRAC_BITS));
      return COEF_W'($urandom);
   endfunction

   task automatic random_config();
      int pick;
      logic [COEF_W-1:0] cnt;
      pick = $urandom_range(0, 99);
      if (pick < 40)      cnt = COEF_W'($urandom_range(1, 8));
      else if (pick < 65) cnt = COEF_W'($urandom_range(9, MAX_PARTICLES - 1));
      else if (pick < 80) cnt = COEF_W'(MAX_PARTICLES);
      else if (pick < 90)
         cnt = COEF_W'($urandom_range(MAX_PARTICLES + 1, 2 ** CNT_REG_W - 1));
      else                cnt = '0;
      write_reg(CSR_SIGMA, pick_coef(SIGMA_RST));
      write_reg(CSR_RHO, pick_coef(RHO_RST));
      write_reg(CSR_BETA, pick_coef(BETA_RST));
      write_reg(CSR_PAUSED, ($urandom_range(0, 99) < 15) ? 24'd1 : 24'd0);
      write_reg(CSR_COUNT, cnt);
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(0, 99) >= stall_pct);
   end

   // Compare each delivered word with the oldest expectation
   always @(posedge clock) begin
      pos_word_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_words.size() == 0) begin
            flag_error($sformatf("unexpected word for slot %0d", rsp_ch.slot));
         end else begin
            want = pending_words.pop_front();
            n_words++;
            if (rsp_ch.slot !== want.slot)
               flag_error($sformatf("slot %0d, expected %0d", rsp_ch.slot, want.slot));
            if (rsp_ch.pos_x !== want.x)
               flag_error($sformatf("slot %0d x %h, expected %h", want.slot, rsp_ch.pos_x,
                                    want.x));
            if (rsp_ch.pos_y !== want.y)
               flag_error($sformatf("slot %0d y %h, expected %h", want.slot, rsp_ch.pos_y,
                                    want.y));
            if (rsp_ch.pos_z !== want.z)
               flag_error($sformatf("slot %0d z %h, expected %h", want.slot, rsp_ch.pos_z,
                                    want.z));
            if (rsp_ch.last !== want.last)
               flag_error($sformatf("slot %0d last %b, expected %b", want.slot, rsp_ch.last,
                                    want.last));
         end
      end
   end

   // Main sequence
   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.action    <= ACT_LOAD;
      req_ch.index     <= '0;
      req_ch.load_x    <= '0;
      req_ch.load_y    <= '0;
      req_ch.load_z    <= '0;
      req_ch.step_size <= '0;
      n_bad   = 0;
      n_loads = 0;
      n_ticks = 0;
      n_words = 0;
      n_regs  = 0;
      gap_pct   = 10;
      stall_pct = 61;
      for (int i = 0; i < MAX_PARTICLES; i++) begin
         mem_x[i] = '0;
         mem_y[i] = '0;
         mem_z[i] = '0;
      end
      sigma_r  = SIGMA_RST;
      rho_r    = RHO_RST;
      beta_r   = BETA_RST;
      paused_r = 1'b0;
      count_r  = COUNT_RST;
      build_plan();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[i]) run_row(plan[i]);

      // random traffic: three pacing modes, three register settings each
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin gap_pct = 10; stall_pct = 61; end
            1: begin gap_pct = 61; stall_pct = 10; end
            default: begin gap_pct = 0; stall_pct = 0; end
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            random_config();
            repeat (SEG_ITEMS) run_row(random_row());
         end
      end

      // drain
      req_ch.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Run covered %0d loads and %0d ticks, %0d position words checked,",
               n_loads, n_ticks, n_words);
      $display("with %0d register writes under three send/receive pacing modes.", n_regs);
      if (n_bad == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
